// File: rtl/core/multi_key_edge_long_press_detector_assert.svh
// assertion macros for the key edge and long press detector
`ifndef MULTI_KEY_EDGE_LONG_PRESS_DETECTOR_ASSERT_SVH
`define MULTI_KEY_EDGE_LONG_PRESS_DETECTOR_ASSERT_SVH

// same-cycle implication
`define MKD_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("mkd assertion failed");

// next-cycle implication
`define MKD_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("mkd assertion failed");

`endif

// File: rtl/core/mkd_pkg.sv
// shared types and constants for the key edge and long press detector
`default_nettype none
package mkd_pkg;
	localparam int KEY_W            = 8;
	localparam int TIME_W           = 32;
	localparam int LPT_W            = 16;
	localparam int CFG_DATA_W       = 16;
	localparam int CFG_IDX_W        = 1;
	localparam int NUM_KEYS_DEFAULT = 8;

	localparam logic [LPT_W-1:0] LPT_RESET  = 16'd1000;
	localparam logic [KEY_W-1:0] MASK_RESET = 8'hC0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LONG_PRESS_TIME  = 1'b0,
		REG_FORCED_HIGH_MASK = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic changed;
		logic rise;
		logic fall;
		logic long_press;
	} key_evt_t;
endpackage
`default_nettype wire

// File: rtl/core/mkd_key_cell.sv
// per-key edge, push and long press tracking
`default_nettype none
module mkd_key_cell
	import mkd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              level,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire logic [LPT_W-1:0]  long_press_time,
	output key_evt_t               evt
);
	logic              prev_q;
	logic              pushed_q;
	logic              long_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] held;

	always_comb begin
		held           = now_ms - start_q;
		evt.changed    = level ^ prev_q;
		evt.rise       = evt.changed & level;
		evt.fall       = evt.changed & ~level & ~pushed_q;
		evt.long_press = ~evt.changed & ~level & pushed_q & ~long_q
			& (held > {{(TIME_W-LPT_W){1'b0}}, long_press_time});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b1;
			pushed_q <= 1'b0;
			long_q   <= 1'b0;
		end else if (step) begin
			prev_q <= level;
			if (evt.rise) begin
				pushed_q <= 1'b0;
			end else if (evt.fall) begin
				pushed_q <= 1'b1;
			end
			if (~evt.changed & level) begin
				long_q <= 1'b0;
			end else if (evt.long_press) begin
				long_q <= 1'b1;
			end
		end
	end

	// start time is only read while pushed, and pushed is set when it is written
	always_ff @(posedge clk) begin
		if (step && evt.fall) begin
			start_q <= now_ms;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/multi_key_edge_long_press_detector.sv
// Multi-key edge and long press detector.
// Scan channel: scan_valid / scan_stall with key_levels and time_now_ms.
// Each request is one scan of eight key levels plus a millisecond timestamp.
// Event channel: event_valid / event_stall with changed, long press, rise and
// fall masks, one result per scan, in scan order.
// Configuration: cfg_wr_en, cfg_index, cfg_data; index 0 is the long press
// time in ms, index 1 the mask of keys that always read high. Write only
// while no scan is in flight.
// Each accepted scan is held in the input register; its events are computed
// from it in the key cells and stored in the result register, which drives
// the event channel. Throughput: one scan per cycle while the receiver does
// not stall; the per-key state update in the key cells is the only loop.
// The input register and the result register act as a two-entry pipeline:
// a new scan is taken while a finished result waits, and scan_stall rises
// only when both are full and the receiver stalls.
// Reset: all keys read as previously high, no key pushed, no long press
// marked, long press time 1000 ms, keys 6 and 7 forced high, pipeline empty.
`default_nettype none
module multi_key_edge_long_press_detector
	import mkd_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  scan_valid,
	output logic                       scan_stall,
	input  wire logic [KEY_W-1:0]      key_levels,
	input  wire logic [TIME_W-1:0]     time_now_ms,
	output logic                       event_valid,
	input  wire logic                  event_stall,
	output logic [KEY_W-1:0]           changed_mask,
	output logic [KEY_W-1:0]           long_press_mask,
	output logic [KEY_W-1:0]           rise_mask,
	output logic [KEY_W-1:0]           fall_mask,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	logic [LPT_W-1:0]  long_press_time_q;
	logic [KEY_W-1:0]  forced_high_q;
	logic              valid_s1;
	logic [KEY_W-1:0]  key_levels_s1;
	logic [TIME_W-1:0] time_s1;
	logic              valid_s2;
	logic [KEY_W-1:0]  changed_s2;
	logic [KEY_W-1:0]  long_s2;
	logic [KEY_W-1:0]  rise_s2;
	logic [KEY_W-1:0]  fall_s2;
	logic              advance;
	logic              step;
	logic [KEY_W-1:0]  levels;
	key_evt_t          evt [KEY_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_time_q <= LPT_RESET;
			forced_high_q     <= MASK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LONG_PRESS_TIME:  long_press_time_q <= cfg_data[LPT_W-1:0];
				REG_FORCED_HIGH_MASK: forced_high_q     <= cfg_data[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance    = ~valid_s2 | ~event_stall;
	assign step       = valid_s1 & advance;
	assign scan_stall = valid_s1 & ~advance;
	assign levels     = key_levels_s1 | forced_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (~scan_stall) begin
				valid_s1 <= scan_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_valid && !scan_stall) begin
			key_levels_s1 <= key_levels;
			time_s1       <= time_now_ms;
		end
	end

	for (genvar g = 0; g < KEY_W; g++) begin : g_key
		if (g < NUM_KEYS) begin : g_used
			mkd_key_cell u_cell (
				.clk             (clk),
				.arst_n          (arst_n),
				.step            (step),
				.level           (levels[g]),
				.now_ms          (time_s1),
				.long_press_time (long_press_time_q),
				.evt             (evt[g])
			);
		end else begin : g_unused
			// no pin: always high, never an event
			assign evt[g] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < KEY_W; i++) begin
				changed_s2[i] <= evt[i].changed;
				long_s2[i]    <= evt[i].long_press;
				rise_s2[i]    <= evt[i].rise;
				fall_s2[i]    <= evt[i].fall;
			end
		end
	end

	assign event_valid     = valid_s2;
	assign changed_mask    = changed_s2;
	assign long_press_mask = long_s2;
	assign rise_mask       = rise_s2;
	assign fall_mask       = fall_s2;
endmodule
`default_nettype wire

// File: rtl/core/mkd_checker.sv
// port-level checks for the key edge and long press detector
`default_nettype none
`include "multi_key_edge_long_press_detector_assert.svh"
module mkd_checker
	import mkd_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             event_valid,
	input wire logic             event_stall,
	input wire logic [KEY_W-1:0] changed_mask,
	input wire logic [KEY_W-1:0] long_press_mask,
	input wire logic [KEY_W-1:0] rise_mask,
	input wire logic [KEY_W-1:0] fall_mask
);
	`MKD_ASSERT_NXT(a_evt_hold, clk, arst_n, event_valid && event_stall, event_valid)
	`MKD_ASSERT_NXT(a_evt_stable, clk, arst_n, event_valid && event_stall, $stable(changed_mask) && $stable(long_press_mask) && $stable(rise_mask) && $stable(fall_mask))
	`MKD_ASSERT_IMP(a_rise_fall_excl, clk, arst_n, event_valid, (rise_mask & fall_mask) == '0)
	`MKD_ASSERT_IMP(a_edges_changed, clk, arst_n, event_valid, ((rise_mask | fall_mask) & ~changed_mask) == '0)
	`MKD_ASSERT_IMP(a_long_unchanged, clk, arst_n, event_valid, (long_press_mask & changed_mask) == '0)
endmodule

bind multi_key_edge_long_press_detector mkd_checker u_mkd_checker (.*);
`default_nettype wire
